/* hw/rtl/pab_pkg.sv */
package pab_pkg;

	// Operation of the shared arithmetic unit
	typedef enum logic {
		ALU_MIX  = 1'b0,
		ALU_DIST = 1'b1
	} alu_op_t;

	// Request codes
	typedef enum logic [1:0] {
		REQ_PAL_WR = 2'd0,
		REQ_PIX_WR = 2'd1,
		REQ_PIX_RD = 2'd2,
		REQ_BLEND  = 2'd3
	} req_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_PITCH  = 2'd2;

	// Squared RGB distance: at most 3*255*255, fits 18 bits
	localparam int DIST_W = 18;

endpackage

/* hw/rtl/pab_alu.sv */
module pab_alu (
	input  logic                         clk,
	input  pab_pkg::alu_op_t             op,
	input  logic [7:0]                   alpha,
	input  logic [7:0]                   src_c,
	input  logic [7:0]                   tgt_c,
	input  logic [23:0]                  pal_rgb,
	input  logic [23:0]                  mix_rgb,
	output logic [pab_pkg::DIST_W-1:0]   res_q
);
	import pab_pkg::*;

	logic [15:0] mix_sum;
	logic [16:0] div_t;
	logic [8:0]  dr, dg, db;
	logic [17:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0] dist_sum;

	// Mix one channel, then divide by 255: (v + 1 + v/256) / 256 is exact for every v up to 255*255
	assign mix_sum = 16'(src_c * (8'd255 - alpha)) + 16'(tgt_c * alpha);
	assign div_t   = {1'b0, mix_sum} + 17'd1 + {9'd0, mix_sum[15:8]};

	// Squared distance between mixed color and one palette entry
	assign dr   = {1'b0, mix_rgb[23:16]} - {1'b0, pal_rgb[23:16]};
	assign dg   = {1'b0, mix_rgb[15:8]}  - {1'b0, pal_rgb[15:8]};
	assign db   = {1'b0, mix_rgb[7:0]}   - {1'b0, pal_rgb[7:0]};
	assign sq_r = 18'($signed(dr) * $signed(dr));
	assign sq_g = 18'($signed(dg) * $signed(dg));
	assign sq_b = 18'($signed(db) * $signed(db));
	assign dist_sum = sq_r + sq_g + sq_b;

	// Register the selected result
	always_ff @(posedge clk) begin
		case (op)
			ALU_MIX:  res_q <= DIST_W'(div_t[15:8]);
			ALU_DIST: res_q <= dist_sum;
			default:  res_q <= dist_sum;
		endcase
	end

endmodule

/* hw/rtl/palette_alpha_blend_rectangle.sv */
// Channel   Signals                                          Transfer
// request   start, busy, req_type, pos_x .. blue_in          start high while busy low
// result    done, read_value, status_code, pixels_changed    one-cycle done strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        valid and ready high
//
// A blend with nothing covered, or with alpha zero, goes to done without touching the
// frame; else each covered pixel in turn is read, mixed and written, its time set by
// the 256-entry nearest-color search through the single palette read port.
// Reset clears control, result and config registers only; frame and palette stores hold nothing defined.
// The receiver cannot stall: each result stands for one cycle on done.
module palette_alpha_blend_rectangle #(
	parameter int MAX_PITCH    = 1024,
	parameter int MAX_HEIGHT   = 512,
	parameter int PALETTE_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [10:0] rect_w,
	input  logic [10:0] rect_h,
	input  logic [7:0]  color_index,
	input  logic [10:0] alpha_level,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        done,
	output logic [7:0]  read_value,
	output logic        status_code,
	output logic [19:0] pixels_changed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import pab_pkg::*;

	localparam int XW    = $clog2(MAX_PITCH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_PITCH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PALETTE_SIZE);
	localparam logic [13:0] MAXP14 = 14'(MAX_PITCH);
	localparam logic [13:0] MAXH14 = 14'(MAX_HEIGHT);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_TGT, S_ADDR, S_FRD, S_FWT, S_PWT, S_MIX, S_SRCH, S_WR, S_DONE
	} state_t;

	state_t state_q;

	// Config registers
	logic [10:0] fw_q, pitch_q;
	logic [9:0]  fh_q;

	// Latched request
	req_t        req_q;
	logic [11:0] x_q, y_q;
	logic [10:0] w_q, h_q;
	logic [7:0]  ci_q, al_q;
	logic [23:0] rgb_q;

	// Walk state
	logic [XW-1:0] px_q, x0_q;
	logic [XW:0]   x1_q;
	logic [YW-1:0] py_q;
	logic [YW:0]   y1_q;
	logic [AW-1:0] addr_q;
	logic [23:0]   tgt_q, src_q, mix_q;
	logic [1:0]    k_q;
	logic [PW+1:0] cnt_q;
	logic [DIST_W-1:0] best_q;
	logic [PW-1:0] bidx_q;
	logic [7:0]    rd_q;
	logic          st_q;
	logic [19:0]   pc_q;

	// Memories
	logic [7:0]  frame_mem [DEPTH];
	logic [23:0] pal_mem   [PALETTE_SIZE];
	logic [7:0]  f_rdata_q;
	logic [23:0] p_rdata_q;
	logic [AW-1:0] f_raddr;
	logic [PW-1:0] p_raddr;
	logic          f_we, p_we;
	logic [7:0]    f_wdata;

	// Decode helpers
	logic signed [13:0] xs, ys, fws, fhs, x0s, y0s, x1s, y1s, xe, ye;
	logic [13:0] fw_e, fh_e, pitch_e;
	logic        out_frame, empty;
	logic [7:0]  al_c;

	// ALU hookup
	alu_op_t     alu_op;
	logic [7:0]  alu_s, alu_t;
	logic [DIST_W-1:0] alu_res;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign read_value     = rd_q;
	assign status_code    = st_q;
	assign pixels_changed = pc_q;

	// Effective sizes and clipping
	always_comb begin
		fw_e    = ({3'd0, fw_q} > MAXP14) ? MAXP14 : {3'd0, fw_q};
		fh_e    = ({4'd0, fh_q} > MAXH14) ? MAXH14 : {4'd0, fh_q};
		pitch_e = ({3'd0, pitch_q} > MAXP14) ? MAXP14 : {3'd0, pitch_q};
		fws  = $signed(fw_e);
		fhs  = $signed(fh_e);
		xs   = 14'($signed(x_q));
		ys   = 14'($signed(y_q));
		out_frame = xs < 0 || ys < 0 || xs >= fws || ys >= fhs;
		x0s  = (xs < 0) ? 14'sd0 : xs;
		y0s  = (ys < 0) ? 14'sd0 : ys;
		xe   = xs + $signed({3'd0, w_q});
		ye   = ys + $signed({3'd0, h_q});
		x1s  = (xe > fws) ? fws : xe;
		y1s  = (ye > fhs) ? fhs : ye;
		empty = (x0s >= x1s) || (y0s >= y1s);
	end

	// Clamp alpha
	always_comb begin
		if ($signed(alpha_level) < 0)
			al_c = 8'd0;
		else if ($signed(alpha_level) > 11'sd255)
			al_c = 8'd255;
		else
			al_c = alpha_level[7:0];
	end

	// Memory port selection
	always_comb begin
		f_raddr = addr_q;
		f_we    = 1'b0;
		f_wdata = ci_q;
		p_we    = (state_q == S_DECODE) && (req_q == REQ_PAL_WR);
		p_raddr = ci_q[PW-1:0];
		if (state_q == S_FRD && req_q == REQ_PIX_WR)
			f_we = 1'b1;
		if (state_q == S_WR) begin
			f_we    = 1'b1;
			f_wdata = 8'(bidx_q);
		end
		if (state_q == S_FWT)
			p_raddr = f_rdata_q[PW-1:0];
		else if (state_q == S_SRCH)
			p_raddr = cnt_q[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (f_we)
			frame_mem[addr_q] <= f_wdata;
		f_rdata_q <= frame_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we)
			pal_mem[ci_q[PW-1:0]] <= rgb_q;
		p_rdata_q <= pal_mem[p_raddr];
	end

	// Shared unit operands
	always_comb begin
		alu_op = (state_q == S_SRCH) ? ALU_DIST : ALU_MIX;
		case (k_q)
			2'd0:    begin alu_s = src_q[23:16]; alu_t = tgt_q[23:16]; end
			2'd1:    begin alu_s = src_q[15:8];  alu_t = tgt_q[15:8];  end
			default: begin alu_s = src_q[7:0];   alu_t = tgt_q[7:0];   end
		endcase
	end

	pab_alu u_alu (
		.clk     (clk),
		.op      (alu_op),
		.alpha   (al_q),
		.src_c   (alu_s),
		.tgt_c   (alu_t),
		.pal_rgb (p_rdata_q),
		.mix_rgb (mix_q),
		.res_q   (alu_res)
	);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= 11'd640;
			fh_q    <= 10'd480;
			pitch_q <= 11'd640;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  fw_q    <= cfg_data;
				CFG_HEIGHT: fh_q    <= cfg_data[9:0];
				CFG_PITCH:  pitch_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_q    <= '0;
			st_q    <= 1'b0;
			pc_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req_t'(req_type);
						x_q   <= pos_x;
						y_q   <= pos_y;
						w_q   <= rect_w;
						h_q   <= rect_h;
						ci_q  <= color_index;
						al_q  <= al_c;
						rgb_q <= {red_in, green_in, blue_in};
						rd_q  <= '0;
						st_q  <= 1'b0;
						pc_q  <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (req_q)
						REQ_PAL_WR: state_q <= S_DONE;
						REQ_PIX_WR, REQ_PIX_RD: begin
							px_q <= XW'(xs);
							py_q <= YW'(ys);
							if (out_frame) begin
								st_q    <= 1'b1;
								state_q <= S_DONE;
							end else begin
								state_q <= S_ADDR;
							end
						end
						default: begin
							px_q <= XW'(x0s);
							x0_q <= XW'(x0s);
							py_q <= YW'(y0s);
							x1_q <= (XW+1)'(x1s);
							y1_q <= (YW+1)'(y1s);
							state_q <= (al_q == 8'd0 || empty) ? S_DONE : S_TGT;
						end
					endcase
				end
				S_TGT: begin
					tgt_q   <= p_rdata_q;
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					addr_q  <= AW'(py_q * pitch_e[XW:0] + (YW+XW+1)'(px_q));
					state_q <= S_FRD;
				end
				S_FRD: begin
					if (req_q == REQ_PIX_WR) begin
						pc_q    <= 20'd1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FWT;
					end
				end
				S_FWT: begin
					if (req_q == REQ_PIX_RD) begin
						rd_q    <= f_rdata_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PWT;
					end
				end
				S_PWT: begin
					src_q   <= p_rdata_q;
					k_q     <= 2'd0;
					state_q <= S_MIX;
				end
				S_MIX: begin
					case (k_q)
						2'd1:    mix_q[23:16] <= alu_res[7:0];
						2'd2:    mix_q[15:8]  <= alu_res[7:0];
						2'd3:    mix_q[7:0]   <= alu_res[7:0];
						default: ;
					endcase
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						cnt_q   <= '0;
						best_q  <= '1;
						bidx_q  <= '0;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					// Compare the entry that has passed the palette read register and the ALU register; strict less keeps lowest index
					if (cnt_q >= (PW+2)'(2) && alu_res < best_q) begin
						best_q <= alu_res;
						bidx_q <= PW'(cnt_q - (PW+2)'(2));
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (PW+2)'(PALETTE_SIZE + 1))
						state_q <= S_WR;
				end
				S_WR: begin
					pc_q <= pc_q + 20'd1;
					if ({1'b0, px_q} + 1'b1 < x1_q) begin
						px_q    <= px_q + 1'b1;
						state_q <= S_ADDR;
					end else if ({1'b0, py_q} + 1'b1 < y1_q) begin
						px_q    <= x0_q;
						py_q    <= py_q + 1'b1;
						state_q <= S_ADDR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a request");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accept did not start work");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result shown twice");
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !(f_we || p_we)) else $error("store write while idle");

endmodule
